FILE: rtl/core/i2ctbe_pkg.sv
package i2ctbe_pkg;

    // Line change classification
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_STOP    = 3'd2,
        EV_FALL    = 3'd3,
        EV_RISE    = 3'd4,
        EV_INVALID = 3'd5
    } t_bus_event;

    // Configuration register indexes
    localparam logic [2:0] CFG_ADDR_0   = 3'd0;
    localparam logic [2:0] CFG_ADDR_1   = 3'd1;
    localparam logic [2:0] CFG_ADDR_2   = 3'd2;
    localparam logic [2:0] CFG_ADDR_3   = 3'd3;
    localparam logic [2:0] CFG_ADDR_EN  = 3'd4;

    localparam int NUM_TARGETS = 4;

    // Change codes: {changed lines, new lines}, each as {scl, sda}
    localparam logic [3:0] CODE_START_SDA  = 4'b0110;
    localparam logic [3:0] CODE_START_BOTH = 4'b1110;
    localparam logic [3:0] CODE_STOP       = 4'b0111;
    localparam logic [3:0] CODE_FALL       = 4'b1000;
    localparam logic [3:0] CODE_RISE       = 4'b1010;
    localparam logic [3:0] CODE_SCL_MASK   = 4'b1110;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [6:0] addr_0;
        logic [6:0] addr_1;
        logic [6:0] addr_2;
        logic [6:0] addr_3;
        logic [3:0] addr_en;
    } t_cfg;

    typedef struct packed {
        logic       pull_sda_low;
        logic [2:0] machine_state;
        logic       receive_valid;
        logic [7:0] receive_byte;
        logic       transmit_loaded;
        logic [1:0] matched_target;
        logic       read_direction;
    } t_fsm_out;

endpackage

FILE: rtl/core/i2c_target_bit_engine_top.sv
// I2C target bit engine.
// Each request on the slave stream is one sample of the SCL and SDA lines plus
// the byte to send next; each sample gives exactly one result on the master
// stream: the classified line change, the SDA drive, the target state, a
// received byte with its strobe, a transmit-load strobe and the matched target.
// The user must write addresses and their enable mask on the configuration port
// only while the stream is idle; the block does not enforce it. Writes to unused
// indexes are ignored. A sample accepted at one edge has its result in the
// output register from the next cycle. One sample is accepted every cycle
// unless the receiver stalls, as the line classification and the target machine
// both settle combinationally. A result waiting in the output register does not
// block the input while the receiver takes it in the same cycle; if the receiver
// stalls, the input stalls with it and the held result stays unchanged.
// Reset leaves the machine ready, both lines assumed high, the read direction
// set, all addresses zero and disabled, and the output register empty.
module i2c_target_bit_engine_top
    import i2ctbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] scl_level, [1] sda_level, [9:2] transmit_byte, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] bus_event, [3] pull_sda_low, [6:4] machine_state, [7] receive_valid,
    // [15:8] receive_byte, [16] transmit_loaded, [18:17] matched_target,
    // [19] read_direction, [23:20] zero
    output logic [23:0] m_axis_tdata
);

    t_cfg       r_cfg;
    logic       w_step;
    t_bus_event w_event;
    t_fsm_out   w_result;
    logic       r_m_valid;
    logic [23:0] r_m_data;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ADDR_0:  r_cfg.addr_0  <= i_cfg_data;
                CFG_ADDR_1:  r_cfg.addr_1  <= i_cfg_data;
                CFG_ADDR_2:  r_cfg.addr_2  <= i_cfg_data;
                CFG_ADDR_3:  r_cfg.addr_3  <= i_cfg_data;
                CFG_ADDR_EN: r_cfg.addr_en <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    i2ctbe_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_scl   (s_axis_tdata[0]),
        .i_sda   (s_axis_tdata[1]),
        .o_event (w_event)
    );

    i2ctbe_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_event   (w_event),
        .i_sda     (s_axis_tdata[1]),
        .i_tx_byte (s_axis_tdata[9:2]),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_step) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_m_data <= {4'd0,
                         w_result.read_direction,
                         w_result.matched_target,
                         w_result.transmit_loaded,
                         w_result.receive_byte,
                         w_result.receive_valid,
                         w_result.machine_state,
                         w_result.pull_sda_low,
                         w_event};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: rtl/core/i2ctbe_classify.sv
module i2ctbe_classify
    import i2ctbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_scl,
    input  logic       i_sda,
    output t_bus_event o_event
);

    logic [1:0] r_prev_lines;
    logic [1:0] w_lines;
    logic [3:0] w_code;

    assign w_lines = {i_scl, i_sda};
    assign w_code  = {w_lines ^ r_prev_lines, w_lines};

    always_comb begin
        priority if (w_lines == r_prev_lines) begin
            o_event = EV_NONE;
        end else if (w_code == CODE_START_SDA || w_code == CODE_START_BOTH) begin
            o_event = EV_START;
        end else if (w_code == CODE_STOP) begin
            o_event = EV_STOP;
        end else if ((w_code & CODE_SCL_MASK) == CODE_FALL) begin
            o_event = EV_FALL;
        end else if ((w_code & CODE_SCL_MASK) == CODE_RISE) begin
            o_event = EV_RISE;
        end else begin
            o_event = EV_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lines <= 2'b11;
        end else if (i_step) begin
            r_prev_lines <= w_lines;
        end
    end

endmodule

FILE: rtl/core/i2ctbe_fsm.sv
module i2ctbe_fsm
    import i2ctbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_bus_event i_event,
    input  logic       i_sda,
    input  logic [7:0] i_tx_byte,
    input  t_cfg       i_cfg,
    output t_fsm_out   o_result
);

    typedef enum logic [2:0] {
        ST_READY    = 3'd0,
        ST_ADDR     = 3'd1,
        ST_ACK_ADDR = 3'd2,
        ST_READ     = 3'd3,
        ST_WRITE    = 3'd4,
        ST_ACK      = 3'd5,
        ST_STOP_END = 3'd6,
        ST_READ_END = 3'd7
    } t_state;

    t_state     r_state,  n_state;
    logic [3:0] r_bits,   n_bits;
    logic [7:0] r_shift,  n_shift;
    logic       r_dir,    n_dir;
    logic [1:0] r_idx,    n_idx;
    logic       r_drive,  n_drive;

    logic       w_rx_valid;
    logic [7:0] w_rx_byte;
    logic       w_tx_loaded;
    logic       w_bits_bad;
    logic [3:0] w_bits_dec;
    logic [7:0] w_shift_in;
    logic       w_match;
    logic [1:0] w_match_idx;
    logic [6:0] w_addr [NUM_TARGETS];

    assign w_addr[0] = i_cfg.addr_0;
    assign w_addr[1] = i_cfg.addr_1;
    assign w_addr[2] = i_cfg.addr_2;
    assign w_addr[3] = i_cfg.addr_3;

    assign w_bits_bad = (r_bits == 4'd0) || (r_bits > BITS_PER_BYTE);
    assign w_bits_dec = r_bits - 4'd1;
    assign w_shift_in = {r_shift[6:0], i_sda};

    // Lowest enabled index wins, so scan downwards and let the last hit stand.
    always_comb begin
        w_match     = 1'b0;
        w_match_idx = 2'd0;
        for (int i = NUM_TARGETS - 1; i >= 0; i--) begin
            if (i_cfg.addr_en[i] && (w_addr[i] == r_shift[6:0])) begin
                w_match     = 1'b1;
                w_match_idx = 2'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_shift     = r_shift;
        n_dir       = r_dir;
        n_idx       = r_idx;
        n_drive     = r_drive;
        w_rx_valid  = 1'b0;
        w_rx_byte   = 8'd0;
        w_tx_loaded = 1'b0;

        if (i_step && i_event != EV_NONE && i_event != EV_INVALID) begin
            if (i_event == EV_START && r_state != ST_READY) begin
                n_state = ST_ADDR;
                n_bits  = BITS_PER_BYTE;
                n_shift = 8'd0;
                n_drive = 1'b0;
            end else begin
                unique case (r_state)
                    ST_READY: begin
                        if (i_event == EV_START) begin
                            n_state = ST_ADDR;
                            n_bits  = BITS_PER_BYTE;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end
                    end
                    ST_ADDR: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_RISE) begin
                            if (w_bits_bad) begin
                                n_state = ST_READY;
                                n_bits  = 4'd0;
                                n_shift = 8'd0;
                                n_drive = 1'b0;
                            end else if (w_bits_dec != 4'd0) begin
                                n_bits  = w_bits_dec;
                                n_shift = w_shift_in;
                            end else if (w_match) begin
                                // Eighth rise carries the read/write bit.
                                n_bits  = 4'd0;
                                n_dir   = i_sda;
                                n_idx   = w_match_idx;
                                n_state = ST_ACK_ADDR;
                                n_drive = 1'b0;
                                if (i_sda) begin
                                    n_shift     = i_tx_byte;
                                    w_tx_loaded = 1'b1;
                                end else begin
                                    n_shift = 8'd0;
                                end
                            end else begin
                                n_state = ST_READY;
                                n_bits  = 4'd0;
                                n_shift = 8'd0;
                                n_drive = 1'b0;
                            end
                        end
                    end
                    ST_ACK_ADDR: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_FALL) begin
                            n_drive = 1'b1;
                        end else if (i_event == EV_RISE) begin
                            n_state = r_dir ? ST_READ : ST_WRITE;
                            n_bits  = BITS_PER_BYTE;
                        end
                    end
                    ST_WRITE: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_RISE) begin
                            if (w_bits_bad) begin
                                n_state = ST_READY;
                                n_bits  = 4'd0;
                                n_shift = 8'd0;
                                n_drive = 1'b0;
                            end else begin
                                n_bits  = w_bits_dec;
                                n_shift = w_shift_in;
                                if (w_bits_dec == 4'd0) begin
                                    n_state = ST_ACK;
                                    n_shift = 8'd0;
                                    if (r_dir) begin
                                        n_shift     = i_tx_byte;
                                        w_tx_loaded = 1'b1;
                                    end else begin
                                        w_rx_valid = 1'b1;
                                        w_rx_byte  = w_shift_in;
                                    end
                                end
                            end
                        end else if (i_event == EV_FALL) begin
                            n_drive = 1'b0;
                        end
                    end
                    ST_READ: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_FALL) begin
                            if (w_bits_bad) begin
                                n_state = ST_READY;
                                n_bits  = 4'd0;
                                n_shift = 8'd0;
                                n_drive = 1'b0;
                            end else begin
                                n_bits  = w_bits_dec;
                                n_drive = ~r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                            end
                        end else if (i_event == EV_RISE) begin
                            if (r_bits == 4'd0) begin
                                n_state = ST_ACK;
                                n_shift = 8'd0;
                                if (r_dir) begin
                                    n_shift     = i_tx_byte;
                                    w_tx_loaded = 1'b1;
                                end else begin
                                    w_rx_valid = 1'b1;
                                    w_rx_byte  = r_shift;
                                end
                            end
                        end
                    end
                    ST_ACK: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_STOP_END;
                        end else if (i_event == EV_FALL) begin
                            n_drive = ~r_dir;
                        end else if (i_event == EV_RISE) begin
                            if (r_dir) begin
                                // A high data line here is the master's NAK.
                                n_state = i_sda ? ST_READ_END : ST_READ;
                            end else begin
                                n_state = ST_WRITE;
                            end
                            n_bits = BITS_PER_BYTE;
                        end
                    end
                    ST_STOP_END: begin
                        if (i_event == EV_RISE) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_FALL) begin
                            n_drive = 1'b0;
                        end
                    end
                    ST_READ_END: begin
                        if (i_event == EV_STOP) begin
                            n_state = ST_READY;
                            n_bits  = 4'd0;
                            n_shift = 8'd0;
                            n_drive = 1'b0;
                        end else if (i_event == EV_FALL) begin
                            n_drive = 1'b0;
                        end
                    end
                    default: begin
                        n_state = ST_READY;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_dir   <= 1'b1;
            r_idx   <= 2'd0;
            r_drive <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_dir   <= n_dir;
            r_idx   <= n_idx;
            r_drive <= n_drive;
        end
    end

    assign o_result.pull_sda_low    = n_drive;
    assign o_result.machine_state   = n_state;
    assign o_result.receive_valid   = w_rx_valid;
    assign o_result.receive_byte    = w_rx_byte;
    assign o_result.transmit_loaded = w_tx_loaded;
    assign o_result.matched_target  = n_idx;
    assign o_result.read_direction  = n_dir;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import i2ctbe_pkg::*;

    typedef enum logic [2:0] {
        TS_READY,
        TS_ADDR,
        TS_ADDR_ACK,
        TS_READ,
        TS_WRITE,
        TS_ACK,
        TS_STOP_END,
        TS_READ_END
    } t_target_state;

    // Same layout as the result stream, lowest field last.
    typedef struct packed {
        logic [3:0] pad;
        logic       read_direction;
        logic [1:0] matched_target;
        logic       transmit_loaded;
        logic [7:0] receive_byte;
        logic       receive_valid;
        logic [2:0] machine_state;
        logic       pull_sda_low;
        logic [2:0] bus_event;
    } t_result;

    localparam logic [1:0] DIRECTED_LINES [15] = '{
        2'b11, 2'b10, 2'b00, 2'b01, 2'b11, 2'b00, 2'b11, 2'b10,
        2'b01, 2'b10, 2'b11, 2'b01, 2'b11, 2'b10, 2'b11
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = CFG_ADDR_0;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // Target engine copy used to work out each expected result
    logic [6:0]    addr_cfg [NUM_TARGETS] = '{default: '0};
    logic [3:0]    addr_en_cfg = '0;
    t_target_state eng_state = TS_READY;
    logic [1:0]    prev_lines = 2'b11;
    logic [3:0]    bits_left = '0;
    logic [7:0]    shift_reg = '0;
    logic          dir_flag = 1'b1;
    logic [1:0]    tgt_idx = '0;
    logic          sda_drive = 1'b0;
    logic          rx_valid, tx_loaded;
    logic [7:0]    rx_byte, tx_in;

    logic [15:0] line_samples [$];
    t_result     expected_results [$];
    t_result     got_res, want_res;

    logic cur_scl = 1'b1;
    logic cur_sda = 1'b1;
    int   pushed = 0;
    int   samples_taken = 0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   break_in = 0;
    int   tx_gap = 0;
    int   rx_hold = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    bit   long_hold_done = 1'b0;

    i2c_target_bit_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void go_ready();
        eng_state = TS_READY;
        sda_drive = 1'b0;
        shift_reg = '0;
        bits_left = '0;
    endfunction

    function automatic void go_addr();
        eng_state = TS_ADDR;
        bits_left = BITS_PER_BYTE;
        shift_reg = '0;
        sda_drive = 1'b0;
    endfunction

    function automatic void load_tx();
        shift_reg = tx_in;
        tx_loaded = 1'b1;
    endfunction

    function automatic void go_ack();
        eng_state = TS_ACK;
        if (!dir_flag) begin
            rx_valid = 1'b1;
            rx_byte  = shift_reg;
        end
        shift_reg = '0;
        if (dir_flag) load_tx();
    endfunction

    // A bit is due but the counter has run out of range: edges were lost.
    function automatic bit bits_bad();
        return bits_left == 0 || bits_left > BITS_PER_BYTE;
    endfunction

    function automatic void step_machine(input t_bus_event ev, input logic sda);
        int hit;
        if (ev == EV_START && eng_state != TS_READY) begin
            go_addr();
            return;
        end
        case (eng_state)
            TS_READY: begin
                if (ev == EV_START) go_addr();
            end
            TS_ADDR: begin
                if (ev == EV_STOP) begin
                    go_ready();
                end else if (ev == EV_RISE) begin
                    if (bits_bad()) begin
                        go_ready();
                        return;
                    end
                    bits_left = bits_left - 1'b1;
                    if (bits_left == 0) begin
                        hit = -1;
                        for (int i = NUM_TARGETS - 1; i >= 0; i--)
                            if (addr_en_cfg[i] && addr_cfg[i] == shift_reg[6:0]) hit = i;
                        if (hit >= 0) begin
                            dir_flag  = sda;
                            tgt_idx   = hit[1:0];
                            eng_state = TS_ADDR_ACK;
                            shift_reg = '0;
                            sda_drive = 1'b0;
                            if (dir_flag) load_tx();
                        end else begin
                            go_ready();
                        end
                    end else begin
                        shift_reg = {shift_reg[6:0], sda};
                    end
                end
            end
            TS_ADDR_ACK: begin
                if (ev == EV_STOP) begin
                    go_ready();
                end else if (ev == EV_FALL) begin
                    sda_drive = 1'b1;
                end else if (ev == EV_RISE) begin
                    eng_state = dir_flag ? TS_READ : TS_WRITE;
                    bits_left = BITS_PER_BYTE;
                end
            end
            TS_WRITE: begin
                if (ev == EV_STOP) begin
                    go_ready();
                end else if (ev == EV_RISE) begin
                    if (bits_bad()) begin
                        go_ready();
                        return;
                    end
                    bits_left = bits_left - 1'b1;
                    shift_reg = {shift_reg[6:0], sda};
                    if (bits_left == 0) go_ack();
                end else if (ev == EV_FALL) begin
                    sda_drive = 1'b0;
                end
            end
            TS_READ: begin
                if (ev == EV_STOP) begin
                    go_ready();
                end else if (ev == EV_FALL) begin
                    if (bits_bad()) begin
                        go_ready();
                        return;
                    end
                    bits_left = bits_left - 1'b1;
                    sda_drive = ~shift_reg[7];
                    shift_reg = {shift_reg[6:0], 1'b0};
                end else if (ev == EV_RISE) begin
                    if (bits_left == 0) go_ack();
                end
            end
            TS_ACK: begin
                if (ev == EV_STOP) begin
                    eng_state = TS_STOP_END;
                end else if (ev == EV_FALL) begin
                    sda_drive = ~dir_flag;
                end else if (ev == EV_RISE) begin
                    if (dir_flag) eng_state = sda ? TS_READ_END : TS_READ;
                    else eng_state = TS_WRITE;
                    bits_left = BITS_PER_BYTE;
                end
            end
            TS_STOP_END: begin
                if (ev == EV_RISE) go_ready();
                else if (ev == EV_FALL) sda_drive = 1'b0;
            end
            default: begin
                if (ev == EV_STOP) go_ready();
                else if (ev == EV_FALL) sda_drive = 1'b0;
            end
        endcase
    endfunction

    function automatic void predict_line_sample(input logic [15:0] sample);
        logic       sda;
        logic [1:0] lines;
        logic [3:0] code;
        t_bus_event ev;
        t_result    res;
        sda       = sample[1];
        lines     = {sample[0], sample[1]};
        tx_in     = sample[9:2];
        ev        = EV_NONE;
        rx_valid  = 1'b0;
        rx_byte   = '0;
        tx_loaded = 1'b0;
        if (lines != prev_lines) begin
            code       = {lines ^ prev_lines, lines};
            prev_lines = lines;
            if (code == CODE_START_SDA || code == CODE_START_BOTH) ev = EV_START;
            else if (code == CODE_STOP) ev = EV_STOP;
            else if ((code & CODE_SCL_MASK) == CODE_FALL) ev = EV_FALL;
            else if ((code & CODE_SCL_MASK) == CODE_RISE) ev = EV_RISE;
            else ev = EV_INVALID;
            if (ev != EV_INVALID) step_machine(ev, sda);
        end
        res                 = '0;
        res.bus_event       = ev;
        res.pull_sda_low    = sda_drive;
        res.machine_state   = eng_state;
        res.receive_valid   = rx_valid;
        res.receive_byte    = rx_byte;
        res.transmit_loaded = tx_loaded;
        res.matched_target  = tgt_idx;
        res.read_direction  = dir_flag;
        expected_results.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 60)
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_line_sample(s_axis_tdata);
                samples_taken++;
                if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : pick_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (line_samples.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= line_samples.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got_res = t_result'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_axis_tdata), 0);
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.bus_event !== want_res.bus_event)
                        report_mismatch("bus_event", int'(got_res.bus_event),
                                        int'(want_res.bus_event));
                    if (got_res.pull_sda_low !== want_res.pull_sda_low)
                        report_mismatch("pull_sda_low", int'(got_res.pull_sda_low),
                                        int'(want_res.pull_sda_low));
                    if (got_res.machine_state !== want_res.machine_state)
                        report_mismatch("machine_state", int'(got_res.machine_state),
                                        int'(want_res.machine_state));
                    if (got_res.receive_valid !== want_res.receive_valid)
                        report_mismatch("receive_valid", int'(got_res.receive_valid),
                                        int'(want_res.receive_valid));
                    if (got_res.receive_byte !== want_res.receive_byte)
                        report_mismatch("receive_byte", int'(got_res.receive_byte),
                                        int'(want_res.receive_byte));
                    if (got_res.transmit_loaded !== want_res.transmit_loaded)
                        report_mismatch("transmit_loaded", int'(got_res.transmit_loaded),
                                        int'(want_res.transmit_loaded));
                    if (got_res.matched_target !== want_res.matched_target)
                        report_mismatch("matched_target", int'(got_res.matched_target),
                                        int'(want_res.matched_target));
                    if (got_res.read_direction !== want_res.read_direction)
                        report_mismatch("read_direction", int'(got_res.read_direction),
                                        int'(want_res.read_direction));
                end
            end
            // One long hold-off part way through a busy stretch, so that the engine backs up.
            if (!long_hold_done && results_seen >= 400 && line_samples.size() > 20) begin
                long_hold_done = 1'b1;
                rx_hold        = 300;
            end else if (rx_hold == 0) begin
                if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
                rx_hold = rx_calm ? 0 : pick_gap();
            end
            m_axis_tready <= (rx_hold == 0);
            if (rx_hold > 0) rx_hold--;
        end
    end

    task automatic put_raw(input logic scl, input logic sda, input logic [7:0] tx);
        line_samples.push_back({6'b0, tx, sda, scl});
        pushed++;
        cur_scl = scl;
        cur_sda = sda;
    endtask

    // Now and then the same lines are sampled twice, which is no change at all.
    task automatic put_lines(input logic scl, input logic sda);
        repeat ($urandom_range(0, 11) == 0 ? 2 : 1) put_raw(scl, sda, 8'($urandom));
    endtask

    task automatic send_start();
        if (cur_scl && cur_sda && $urandom_range(0, 2) == 0) begin
            put_lines(1'b0, 1'b1);
            put_lines(1'b1, 1'b1);
        end
        if (!(cur_scl && cur_sda)) begin
            if (cur_scl) put_lines(1'b0, cur_sda);
            put_lines(1'b0, 1'b1);
            put_lines(1'b1, 1'b1);
        end
        put_lines(1'b1, 1'b0);
        put_lines(1'b0, 1'b0);
    endtask

    task automatic send_stop();
        if (cur_scl) put_lines(1'b0, cur_sda);
        put_lines(1'b0, 1'b0);
        put_lines(1'b1, 1'b0);
        put_lines(1'b1, 1'b1);
    endtask

    // One clock pulse with b on SDA; a broken frame gets line noise injected here.
    task automatic clock_bit(input logic b);
        if (break_in > 0) begin
            break_in--;
            if (break_in == 0)
                repeat ($urandom_range(1, 4)) put_lines(1'($urandom), 1'($urandom));
        end
        if (cur_scl) put_lines(1'b0, cur_sda);
        put_lines(1'b0, b);
        put_lines(1'b1, b);
        put_lines(1'b0, b);
    endtask

    task automatic run_frame(input logic [6:0] addr, input logic rw, input int nbytes);
        send_start();
        for (int i = 6; i >= 0; i--) clock_bit(addr[i]);
        clock_bit(rw);
        clock_bit(1'($urandom));
        for (int n = 0; n < nbytes; n++) begin
            repeat (8) clock_bit(1'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                send_stop();
                return;
            end
            // On a read the master answers NAK on the last byte, and sometimes early.
            if (rw) clock_bit(n == nbytes - 1 || $urandom_range(0, 7) == 0);
            else clock_bit(1'($urandom));
        end
        if ($urandom_range(0, 4) != 0) send_stop();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_taken != pushed || expected_results.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_ADDR_EN) addr_en_cfg = value[3:0];
        else addr_cfg[idx[1:0]] = value;
    endtask

    task automatic set_targets(input logic [6:0] a0, input logic [6:0] a1,
                               input logic [6:0] a2, input logic [6:0] a3,
                               input logic [3:0] mask);
        write_reg(CFG_ADDR_0, a0);
        write_reg(CFG_ADDR_1, a1);
        write_reg(CFG_ADDR_2, a2);
        write_reg(CFG_ADDR_3, a3);
        write_reg(CFG_ADDR_EN, {3'b0, mask});
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [6:0] same_addr;
        logic [6:0] frame_addr;
        int         goal;
        int         r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: set_targets(7'd0, 7'd127, 7'h2A, 7'h55, 4'hF);
                1: set_targets(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 4'h0);
                2: begin
                    // Every slot holds the same address: the lowest enabled one must win.
                    same_addr = 7'($urandom);
                    set_targets(same_addr, same_addr, same_addr, same_addr,
                                4'($urandom_range(1, 15)));
                end
                default: set_targets(7'($urandom), 7'($urandom), 7'($urandom),
                                     7'($urandom), 4'($urandom));
            endcase
            if (ph == 0) begin
                for (int i = 0; i < 15; i++)
                    put_raw(DIRECTED_LINES[i][1], DIRECTED_LINES[i][0], i[0] ? 8'hFF : 8'h00);
            end
            goal = pushed + (ph == 1 ? 60 : 240);
            while (pushed < goal) begin
                r = $urandom_range(0, 99);
                frame_addr = ($urandom_range(0, 4) != 0) ? addr_cfg[2'($urandom_range(0, 3))]
                                                         : 7'($urandom);
                if (r < 70) begin
                    run_frame(frame_addr, 1'($urandom), $urandom_range(0, 3));
                end else if (r < 85) begin
                    break_in = $urandom_range(1, 20);
                    run_frame(frame_addr, 1'($urandom), $urandom_range(0, 3));
                    break_in = 0;
                end else begin
                    repeat ($urandom_range(1, 12)) put_lines(1'($urandom), 1'($urandom));
                end
            end
        end
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: i2c_target_bit_engine_top.f
rtl/core/i2ctbe_pkg.sv
rtl/core/i2ctbe_classify.sv
rtl/core/i2ctbe_fsm.sv
rtl/core/i2c_target_bit_engine_top.sv
tb/tb_top.sv
